// File: hdl/kmq_pkg.sv
// Shared types, codes and constants of the key mode qualifier.
package kmq_pkg;

  // Default table size and fixed field widths.
  localparam int KEY_COUNT_DEF = 512;
  localparam int KEY_W         = 9;
  localparam int VALUE_W       = 8;
  localparam int MODE_W        = 3;
  localparam int COOLDOWN_W    = 16;
  localparam int CYCLES_W      = 8;
  localparam int TIME_W        = 32;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 24;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Action codes carried on the input tuser.
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_SET    = 2'd2;

  // Key modes.
  localparam logic [MODE_W-1:0] MODE_PLAIN    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TOGGLE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COOLDOWN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INSTANT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CYCLE    = 3'd4;

  // Classified command kinds.
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_SAMPLE,
    CMD_SET
  } kmq_kind_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    kmq_kind_t               kind;
    logic [KEY_W-1:0]        key;
    logic                    pressed;
    logic [MODE_W-1:0]       mode;
    logic [VALUE_W-1:0]      value;
    logic [COOLDOWN_W-1:0]   cooldown;
    logic [CYCLES_W-1:0]     cycles;
  } kmq_cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } kmq_q_status_t;

  // Per-key attributes held in one memory word.
  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [VALUE_W-1:0]      value;
    logic [COOLDOWN_W-1:0]   cooldown;
    logic [CYCLES_W-1:0]     cycles;
  } kmq_attr_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_CALC
  } kmq_bk_state_t;

endpackage

// File: hdl/kmq_front.sv
// Input stage: accepts beats, decodes the action and drops items that do nothing.
module kmq_front #(
  parameter int KEY_COUNT = kmq_pkg::KEY_COUNT_DEF
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [kmq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  input  kmq_pkg::kmq_q_status_t         q_status,
  output logic                           push,
  output kmq_pkg::kmq_cmd_t              push_cmd
);
  import kmq_pkg::*;

  logic             accept;
  logic             keep;
  logic [KEY_W-1:0] key;
  logic             in_range;

  // The front only stalls on a full queue.
  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign key       = in_tdata[8:0];
  assign in_range  = (32'(key) < KEY_COUNT);

  // Classify the beat into a command; unused codes and out-of-range keys of sample and set beats are dropped.
  always_comb begin
    keep          = 1'b0;
    push_cmd.kind = CMD_TICK;
    case (in_tuser)
      ACT_TICK: begin
        keep          = 1'b1;
        push_cmd.kind = CMD_TICK;
      end
      ACT_SAMPLE: begin
        keep          = in_range;
        push_cmd.kind = CMD_SAMPLE;
      end
      ACT_SET: begin
        keep          = in_range;
        push_cmd.kind = CMD_SET;
      end
      default: begin
        keep          = 1'b0;
      end
    endcase
    push_cmd.key      = key;
    push_cmd.pressed  = in_tdata[9];
    push_cmd.mode     = in_tdata[12:10];
    push_cmd.value    = in_tdata[20:13];
    push_cmd.cooldown = in_tdata[36:21];
    push_cmd.cycles   = in_tdata[44:37];
  end

  assign push = accept && keep;

endmodule

// File: hdl/kmq_queue.sv
// Short command queue that decouples the front from the back.
module kmq_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  kmq_pkg::kmq_cmd_t      push_cmd,
  input  logic                   pop,
  output kmq_pkg::kmq_cmd_t      head,
  output kmq_pkg::kmq_q_status_t status
);
  import kmq_pkg::*;

  kmq_cmd_t                 slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_PTR_W:0]     cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign head         = slot_r[rd_ptr_r];

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage slots carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hdl/kmq_back.sv
// Execution stage: time base, key table memories, per-key qualification and result register.
module kmq_back #(
  parameter int KEY_COUNT = kmq_pkg::KEY_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kmq_pkg::kmq_cmd_t               head,
  input  kmq_pkg::kmq_q_status_t          q_status,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kmq_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import kmq_pkg::*;

  localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int IW = (AW > KEY_W) ? AW : KEY_W;

  kmq_bk_state_t       state_r, state_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]       cur_addr_r, cur_addr_nxt;
  logic [KEY_W-1:0]    cur_key_r, cur_key_nxt;
  logic                cur_pressed_r, cur_pressed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]    out_key_r, out_key_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;

  kmq_attr_t           attr_mem [KEY_COUNT];
  logic [TIME_W-1:0]   last_mem [KEY_COUNT];
  kmq_attr_t           attr_rd_r;
  logic [TIME_W-1:0]   last_rd_r;

  logic [IW-1:0]       head_key_ext;
  logic [AW-1:0]       rd_addr;
  logic                is_sample;
  logic                out_free;
  logic                clr_last;
  logic                attr_we;
  logic [AW-1:0]       attr_waddr;
  kmq_attr_t           attr_wdata;
  logic                last_we;
  logic [TIME_W-1:0]   last_wdata;
  logic                time_inc;
  logic                load_out;

  logic [TIME_W-1:0]   elapsed;
  logic                gt;
  logic [VALUE_W:0]    v_step;
  logic [VALUE_W-1:0]  v_mid;
  logic [VALUE_W-1:0]  new_v;
  logic                last_upd;
  logic [TIME_W-1:0]   new_last;

  assign head_key_ext = IW'(head.key);
  assign rd_addr      = head_key_ext[AW-1:0];
  assign is_sample    = !q_status.empty && (head.kind == CMD_SAMPLE);
  assign out_free     = !out_valid_r || out_tready;
  assign clr_last     = (clr_cnt_r == AW'(KEY_COUNT - 1));

  // Qualification of one sample from the entry read out of the table.
  always_comb begin
    elapsed  = time_r - last_rd_r;
    gt       = elapsed > TIME_W'(attr_rd_r.cooldown);
    v_step   = {1'b0, attr_rd_r.value} + 1'b1;
    v_mid    = attr_rd_r.value;
    new_v    = attr_rd_r.value;
    last_upd = 1'b0;
    new_last = time_r;
    case (attr_rd_r.mode)
      MODE_TOGGLE: begin
        if (cur_pressed_r && gt) begin
          new_v    = {{(VALUE_W-1){1'b0}}, ~attr_rd_r.value[0]};
          last_upd = 1'b1;
        end else if (!cur_pressed_r) begin
          last_upd = 1'b1;
          new_last = '0;
        end
      end
      MODE_COOLDOWN: begin
        if (cur_pressed_r && attr_rd_r.value == '0) begin
          new_v    = VALUE_W'(1);
          last_upd = 1'b1;
        end else if (gt) begin
          new_v    = '0;
        end
      end
      MODE_INSTANT: begin
        v_mid = (attr_rd_r.value != '0 && !gt) ? '0 : attr_rd_r.value;
        if (cur_pressed_r && v_mid == '0 && gt) begin
          new_v    = VALUE_W'(1);
          last_upd = 1'b1;
        end else begin
          new_v    = v_mid;
        end
      end
      MODE_CYCLE: begin
        if (cur_pressed_r && gt) begin
          new_v    = (v_step >= (VALUE_W+1)'(attr_rd_r.cycles)) ? '0 : v_step[VALUE_W-1:0];
          last_upd = 1'b1;
        end else if (!cur_pressed_r) begin
          last_upd = 1'b1;
          new_last = '0;
        end
      end
      default: begin
        new_v = VALUE_W'(cur_pressed_r);
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_last) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (is_sample && out_free) begin
          state_nxt = BK_CALC;
        end
      end
      BK_CALC: begin
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_CLEAR;
      end
    endcase
  end

  // Sequencer outputs: queue pop, memory writes, time step and result load.
  always_comb begin
    pop        = 1'b0;
    attr_we    = 1'b0;
    attr_waddr = rd_addr;
    attr_wdata = '0;
    last_we    = 1'b0;
    last_wdata = '0;
    time_inc   = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        attr_we    = 1'b1;
        attr_waddr = clr_cnt_r;
        last_we    = 1'b1;
      end
      BK_IDLE: begin
        if (!q_status.empty) begin
          case (head.kind)
            CMD_TICK: begin
              pop      = 1'b1;
              time_inc = 1'b1;
            end
            CMD_SET: begin
              pop        = 1'b1;
              attr_we    = 1'b1;
              attr_wdata = '{mode: head.mode, value: head.value,
                             cooldown: head.cooldown, cycles: head.cycles};
            end
            CMD_SAMPLE: begin
              pop = out_free;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      BK_CALC: begin
        attr_we    = 1'b1;
        attr_waddr = cur_addr_r;
        attr_wdata = '{mode: attr_rd_r.mode, value: new_v,
                       cooldown: attr_rd_r.cooldown, cycles: attr_rd_r.cycles};
        last_we    = last_upd;
        last_wdata = new_last;
        load_out   = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Datapath register next values.
  always_comb begin
    time_nxt        = time_inc ? time_r + 1'b1 : time_r;
    clr_cnt_nxt     = (state_r == BK_CLEAR) ? clr_cnt_r + 1'b1 : clr_cnt_r;
    cur_addr_nxt    = cur_addr_r;
    cur_key_nxt     = cur_key_r;
    cur_pressed_nxt = cur_pressed_r;
    if (pop && is_sample) begin
      cur_addr_nxt    = rd_addr;
      cur_key_nxt     = head.key;
      cur_pressed_nxt = head.pressed;
    end
    out_valid_nxt = out_valid_r && !out_tready;
    out_key_nxt   = out_key_r;
    out_value_nxt = out_value_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_key_nxt   = cur_key_r;
      out_value_nxt = new_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      time_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cur_addr_r    <= cur_addr_nxt;
    cur_key_r     <= cur_key_nxt;
    cur_pressed_r <= cur_pressed_nxt;
    out_key_r     <= out_key_nxt;
    out_value_r   <= out_value_nxt;
  end

  // Attribute memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (attr_we) begin
      attr_mem[attr_waddr] <= attr_wdata;
    end
    attr_rd_r <= attr_mem[rd_addr];
  end

  // Last change time memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (last_we) begin
      last_mem[attr_waddr] <= last_wdata;
    end
    last_rd_r <= last_mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - KEY_W - VALUE_W)'(0), out_value_r, out_key_r};

  // No command leaves the queue while the table is being cleared.
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |-> !pop)
    else $error("command popped during table clear");

  // A result is only loaded when the result register is free.
  a_calc_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CALC) |-> !out_valid_r)
    else $error("result register busy during sample");

  // A new result only appears right after a sample calculation.
  a_out_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == BK_CALC))
    else $error("result appeared without a sample");

  // A tick advances the time base by exactly one.
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !q_status.empty && head.kind == CMD_TICK) |=> (time_r == $past(time_r) + 1'b1))
    else $error("tick did not advance time");

endmodule

// File: hdl/key_mode_qualifier_top.sv
// A sample beat passes the queue slot, the table read register and the result register in turn.
// Tick and set beats are executed straight from the queue head; a sample takes a table read, then a
// write back, bounded by the single read and write port of the key table memories.
// Reset: synchronous, active low; afterwards a clearing pass writes every table entry, and up to
// two beats are queued meanwhile before in_tready drops.
module key_mode_qualifier_top #(
  parameter int KEY_COUNT = kmq_pkg::KEY_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // key_index[8:0], pressed[9], mode[12:10], initial_value[20:13],
  // cooldown_ms[36:21], cycle_count[44:37], zero fill [47:45]
  input  logic [kmq_pkg::IN_DATA_W-1:0]   in_tdata,
  // action[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // key_number[8:0], key_value[16:9], zero fill [23:17]
  output logic [kmq_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import kmq_pkg::*;

  kmq_q_status_t q_status;
  kmq_cmd_t      push_cmd;
  kmq_cmd_t      head;
  logic          push;
  logic          pop;

  // Decode and filter incoming beats.
  kmq_front #(.KEY_COUNT(KEY_COUNT)) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue between the two halves.
  kmq_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  // Key table and qualification.
  kmq_back #(.KEY_COUNT(KEY_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
